>>> rtl/motor_axis_supervisor_fsm_macros.svh
// Assertion helpers used by the checker file.
// Both sample on clk and are switched off while rst_n is low.
`ifndef MOTOR_AXIS_SUPERVISOR_FSM_MACROS_SVH
`define MOTOR_AXIS_SUPERVISOR_FSM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("supervisor check failed");

// Consequent must hold in the cycle after the antecedent.
`define MAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("supervisor check failed");

`endif

>>> rtl/mas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mas_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AXIS_COUNT  = 2;

  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int RAM_DEPTH  = AXIS_COUNT * QUEUE_DEPTH;
  localparam int RA_W       = $clog2(RAM_DEPTH);

  // request functions
  localparam logic FUNC_POST    = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  // result kinds
  localparam logic KIND_POST  = 1'b0;
  localparam logic KIND_TRANS = 1'b1;

  // events
  localparam logic [4:0] EV_FAULT           = 5'd0;
  localparam logic [4:0] EV_POWER_ON_DONE   = 5'd1;
  localparam logic [4:0] EV_SELF_TEST_OK    = 5'd2;
  localparam logic [4:0] EV_CAL_OK          = 5'd3;
  localparam logic [4:0] EV_START_IF        = 5'd4;
  localparam logic [4:0] EV_START_HFI       = 5'd5;
  localparam logic [4:0] EV_OBSERVER_READY  = 5'd6;
  localparam logic [4:0] EV_COAST_REQ       = 5'd7;
  localparam logic [4:0] EV_ALIGN_TO_IF     = 5'd8;
  localparam logic [4:0] EV_ALIGN_TO_HFI    = 5'd9;
  localparam logic [4:0] EV_HFI_CONF_LOST   = 5'd10;
  localparam logic [4:0] EV_ENTER_FW        = 5'd11;
  localparam logic [4:0] EV_BRAKE_REQ       = 5'd12;
  localparam logic [4:0] EV_EXIT_FW         = 5'd13;
  localparam logic [4:0] EV_BRAKE_DONE      = 5'd14;
  localparam logic [4:0] EV_STOP_DONE       = 5'd15;
  localparam logic [4:0] EV_RECOVERY_REQ    = 5'd16;
  localparam logic [4:0] EV_RECOVERY_CAL    = 5'd17;
  localparam logic [4:0] EV_RECOVERY_OK     = 5'd18;
  localparam logic [4:0] EV_RECOVERY_FAILED = 5'd19;
  localparam logic [4:0] EV_START_FAILED    = 5'd20;
  localparam logic [4:0] EV_COUNT           = 5'd21;

  // motor states
  localparam logic [3:0] MS_POWER_ON    = 4'd0;
  localparam logic [3:0] MS_SELF_TEST   = 4'd1;
  localparam logic [3:0] MS_CALIBRATION = 4'd2;
  localparam logic [3:0] MS_IDLE        = 4'd3;
  localparam logic [3:0] MS_ALIGN       = 4'd4;
  localparam logic [3:0] MS_OPEN_LOOP   = 4'd5;
  localparam logic [3:0] MS_HFI_CL      = 4'd6;
  localparam logic [3:0] MS_BLEND       = 4'd7;
  localparam logic [3:0] MS_CLOSED_LOOP = 4'd8;
  localparam logic [3:0] MS_FIELD_WEAK  = 4'd9;
  localparam logic [3:0] MS_BRAKE       = 4'd10;
  localparam logic [3:0] MS_COAST       = 4'd11;
  localparam logic [3:0] MS_FAULT       = 4'd12;
  localparam logic [3:0] MS_RECOVERY    = 4'd13;

  typedef enum logic {
    CS_IDLE,
    CS_DRAIN
  } ctl_state_t;

  typedef struct packed {
    logic       legal;
    logic [3:0] nx;
  } trans_t;

  function automatic logic safe_state(input logic [3:0] s);
    return (s <= MS_IDLE) || (s == MS_COAST) || (s == MS_FAULT);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RA_W-1:0] ring_addr(input logic ax, input logic [PTR_W-1:0] p);
    return ax ? RA_W'(QUEUE_DEPTH) + RA_W'(p) : RA_W'(p);
  endfunction

  function automatic trans_t trans_lookup(input logic [3:0] cur, input logic [4:0] ev);
    trans_t t;
    t.legal = 1'b1;
    t.nx    = MS_FAULT;
    if (ev != EV_FAULT) begin
      t.legal = 1'b0;
      case (cur)
        MS_POWER_ON:    if (ev == EV_POWER_ON_DONE) begin t.legal = 1'b1; t.nx = MS_SELF_TEST; end
        MS_SELF_TEST:   if (ev == EV_SELF_TEST_OK) begin t.legal = 1'b1; t.nx = MS_CALIBRATION; end
        MS_CALIBRATION: if (ev == EV_CAL_OK) begin t.legal = 1'b1; t.nx = MS_IDLE; end
        MS_IDLE: begin
          if (ev == EV_START_IF || ev == EV_START_HFI) begin
            t.legal = 1'b1; t.nx = MS_ALIGN;
          end else if (ev == EV_OBSERVER_READY) begin
            t.legal = 1'b1; t.nx = MS_CLOSED_LOOP;
          end else if (ev == EV_COAST_REQ) begin
            t.legal = 1'b1; t.nx = MS_COAST;
          end
        end
        MS_ALIGN: begin
          if (ev == EV_ALIGN_TO_IF) begin
            t.legal = 1'b1; t.nx = MS_OPEN_LOOP;
          end else if (ev == EV_ALIGN_TO_HFI) begin
            t.legal = 1'b1; t.nx = MS_HFI_CL;
          end
        end
        MS_OPEN_LOOP: if (ev == EV_OBSERVER_READY) begin t.legal = 1'b1; t.nx = MS_BLEND; end
        MS_HFI_CL: begin
          if (ev == EV_HFI_CONF_LOST) begin
            t.legal = 1'b1; t.nx = MS_OPEN_LOOP;
          end else if (ev == EV_OBSERVER_READY) begin
            t.legal = 1'b1; t.nx = MS_BLEND;
          end
        end
        MS_BLEND: if (ev == EV_OBSERVER_READY) begin t.legal = 1'b1; t.nx = MS_CLOSED_LOOP; end
        MS_CLOSED_LOOP: begin
          if (ev == EV_ENTER_FW) begin
            t.legal = 1'b1; t.nx = MS_FIELD_WEAK;
          end else if (ev == EV_BRAKE_REQ) begin
            t.legal = 1'b1; t.nx = MS_BRAKE;
          end else if (ev == EV_COAST_REQ) begin
            t.legal = 1'b1; t.nx = MS_COAST;
          end
        end
        MS_FIELD_WEAK: begin
          if (ev == EV_EXIT_FW) begin
            t.legal = 1'b1; t.nx = MS_CLOSED_LOOP;
          end else if (ev == EV_BRAKE_REQ) begin
            t.legal = 1'b1; t.nx = MS_BRAKE;
          end else if (ev == EV_COAST_REQ) begin
            t.legal = 1'b1; t.nx = MS_COAST;
          end
        end
        MS_BRAKE: begin
          if (ev == EV_BRAKE_DONE) begin
            t.legal = 1'b1; t.nx = MS_IDLE;
          end else if (ev == EV_COAST_REQ) begin
            t.legal = 1'b1; t.nx = MS_COAST;
          end
        end
        MS_COAST: if (ev == EV_STOP_DONE) begin t.legal = 1'b1; t.nx = MS_IDLE; end
        MS_FAULT: if (ev == EV_RECOVERY_REQ) begin t.legal = 1'b1; t.nx = MS_RECOVERY; end
        MS_RECOVERY: begin
          if (ev == EV_RECOVERY_CAL) begin
            t.legal = 1'b1; t.nx = MS_CALIBRATION;
          end else if (ev == EV_RECOVERY_OK) begin
            t.legal = 1'b1; t.nx = MS_IDLE;
          end else if (ev == EV_RECOVERY_FAILED) begin
            t.legal = 1'b1; t.nx = MS_FAULT;
          end
        end
        default: ;
      endcase
      // fallbacks for start failure and coast, else FAULT
      if (!t.legal) begin
        if (ev == EV_START_FAILED && cur != MS_FAULT && cur != MS_RECOVERY) begin
          t.legal = 1'b1; t.nx = MS_FAULT;
        end else if (ev == EV_COAST_REQ && cur > MS_CALIBRATION && cur != MS_COAST &&
                     cur != MS_FAULT && cur != MS_RECOVERY) begin
          t.legal = 1'b1; t.nx = MS_COAST;
        end else begin
          t.nx = MS_FAULT;
        end
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/motor_axis_supervisor_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-axis motor supervisor. Each axis has its own event ring (QUEUE_DEPTH slots, one kept
// empty) held in a single shared ring memory with a registered read port. A post request
// (func 0) queues an event and answers with one registered acknowledge; it is refused
// (accepted=0) for an event code of 21 or above or a full ring. A service request (func 1)
// drains the axis's ring, running each event through the transition table and returning
// one result per event with prior and new state, the illegal flag (FAULT forced, time_ms
// echoed in fault_time) and the safe-outputs flag; last marks the final result. A service
// of an empty ring returns no result; one of n events steps through accept, first ring
// read, then one transition per cycle while the output is not stalled. Output stall holds
// the drain in place. The ring needs no clearing after reset: only written slots are ever
// read.
module motor_axis_supervisor_fsm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic        in_axis,
  input  wire logic [4:0]  in_event_code,
  input  wire logic [31:0] in_time_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic             out_axis_out,
  output logic             out_accepted,
  output logic [4:0]       out_event_out,
  output logic [3:0]       out_prior_state,
  output logic [3:0]       out_new_state,
  output logic             out_illegal,
  output logic             out_safe_outputs,
  output logic [31:0]      out_fault_time,
  output logic             out_last
);
  import mas_pkg::*;

  // control state
  ctl_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]  head_r [AXIS_COUNT];
  logic [PTR_W-1:0]  tail_r [AXIS_COUNT];
  logic [3:0]        axis_state_r [AXIS_COUNT];

  // drain working registers
  logic              ax_r;          // axis being drained
  logic [PTR_W-1:0]  hp_r;          // next slot to prefetch
  logic              rd_vld_r;      // rdata_r holds the event at the head
  logic [31:0]       time_r;

  // ring memory
  logic [4:0]        ring_mem [RAM_DEPTH];
  logic [4:0]        rdata_r;

  // result register
  logic              out_valid_r;
  logic              kind_r, axis_o_r, acc_r, ill_r, safe_r, last_r;
  logic [4:0]        ev_o_r;
  logic [3:0]        prior_r, new_r;
  logic [31:0]       ftime_r;

  // request side
  logic              out_free;
  logic              in_take;
  logic              axis_ok;
  logic [PTR_W-1:0]  tail_inc;
  logic              post_ok;
  logic [3:0]        post_st;
  logic              go_drain;

  // drain side
  logic              consume;
  logic              issue;
  logic [PTR_W-1:0]  head_inc;
  logic              drain_last;
  trans_t            tr;

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && !in_stall;
  assign axis_ok  = (32'(in_axis) < 32'(AXIS_COUNT));

  // post: check range and room, ring keeps one slot empty
  assign tail_inc = ptr_inc(tail_r[in_axis]);
  assign post_ok  = axis_ok && (in_event_code < EV_COUNT) && (tail_inc != head_r[in_axis]);
  assign post_st  = axis_ok ? axis_state_r[in_axis] : MS_FAULT;
  assign go_drain = in_take && (in_func == FUNC_SERVICE) && axis_ok &&
                    (head_r[in_axis] != tail_r[in_axis]);

  // drain: current event comes from the read register, state is read and written back here
  assign head_inc   = ptr_inc(head_r[ax_r]);
  assign drain_last = (head_inc == tail_r[ax_r]);
  assign tr         = trans_lookup(axis_state_r[ax_r], rdata_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:  if (go_drain) state_nxt = CS_DRAIN;
      CS_DRAIN: if (consume && drain_last) state_nxt = CS_IDLE;
      default:  state_nxt = CS_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall = 1'b1;
    consume  = 1'b0;
    issue    = 1'b0;
    unique case (state_r)
      CS_IDLE: in_stall = !out_free;
      CS_DRAIN: begin
        consume = rd_vld_r && out_free;
        // prefetch the next slot as soon as the read register frees up
        issue   = (hp_r != tail_r[ax_r]) && (!rd_vld_r || consume);
      end
      default: ;
    endcase
  end

  // ring memory: one write (post), one registered read (drain prefetch)
  always_ff @(posedge clk) begin
    if (in_take && in_func == FUNC_POST && post_ok) begin
      ring_mem[ring_addr(in_axis, tail_r[in_axis])] <= in_event_code;
    end
    if (issue) begin
      rdata_r <= ring_mem[ring_addr(ax_r, hp_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        head_r[i]       <= '0;
        tail_r[i]       <= '0;
        axis_state_r[i] <= MS_POWER_ON;
      end
    end else begin
      state_r <= state_nxt;

      // a new result loads the register, otherwise a taken result empties it
      if ((in_take && in_func == FUNC_POST) || consume) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (in_take && in_func == FUNC_POST) begin
        if (post_ok) begin
          tail_r[in_axis] <= tail_inc;
        end
        kind_r      <= KIND_POST;
        axis_o_r    <= in_axis;
        acc_r       <= post_ok;
        ev_o_r      <= in_event_code;
        prior_r     <= post_st;
        new_r       <= post_st;
        ill_r       <= 1'b0;
        safe_r      <= safe_state(post_st);
        ftime_r     <= '0;
        last_r      <= 1'b1;
      end

      if (go_drain) begin
        ax_r     <= in_axis;
        hp_r     <= head_r[in_axis];
        time_r   <= in_time_ms;
      end

      if (consume) begin
        head_r[ax_r]       <= head_inc;
        axis_state_r[ax_r] <= tr.nx;
        kind_r      <= KIND_TRANS;
        axis_o_r    <= ax_r;
        acc_r       <= 1'b1;
        ev_o_r      <= rdata_r;
        prior_r     <= axis_state_r[ax_r];
        new_r       <= tr.nx;
        ill_r       <= !tr.legal;
        safe_r      <= safe_state(tr.nx);
        ftime_r     <= tr.legal ? 32'd0 : time_r;
        last_r      <= drain_last;
      end

      if (issue) begin
        rd_vld_r <= 1'b1;
        hp_r     <= ptr_inc(hp_r);
      end else if (consume) begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_axis_out     = axis_o_r;
  assign out_accepted     = acc_r;
  assign out_event_out    = ev_o_r;
  assign out_prior_state  = prior_r;
  assign out_new_state    = new_r;
  assign out_illegal      = ill_r;
  assign out_safe_outputs = safe_r;
  assign out_fault_time   = ftime_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

>>> rtl/mas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "motor_axis_supervisor_fsm_macros.svh"
module mas_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_func,
  input wire logic        in_axis,
  input wire logic [4:0]  in_event_code,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic        out_axis_out,
  input wire logic [4:0]  out_event_out,
  input wire logic [3:0]  out_prior_state,
  input wire logic [3:0]  out_new_state,
  input wire logic        out_illegal,
  input wire logic        out_safe_outputs,
  input wire logic [31:0] out_fault_time,
  input wire logic        out_last
);
  import mas_pkg::*;

  // illegal transition always lands in FAULT with power off
  `MAS_ASSERT_SAME(a_illegal_fault, out_valid && out_illegal,
                   out_new_state == MS_FAULT && out_safe_outputs && out_kind == KIND_TRANS)
  // acknowledge carries no transition and ends its request
  `MAS_ASSERT_SAME(a_post_ack, out_valid && out_kind == KIND_POST,
                   out_prior_state == out_new_state && !out_illegal && out_last)
  // a post answered next cycle echoes the posted event
  `MAS_ASSERT_NEXT(a_post_echo, in_valid && !in_stall && in_func == FUNC_POST,
                   out_valid && out_kind == KIND_POST && out_event_out == $past(in_event_code) &&
                   out_axis_out == $past(in_axis))
  // fault time only shows with the illegal flag
  `MAS_ASSERT_SAME(a_ftime_zero, out_valid && !out_illegal, out_fault_time == 32'd0)
  // stalled result holds
  `MAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_new_state) && $stable(out_last))

endmodule

bind motor_axis_supervisor_fsm mas_checker u_mas_checker (.*);
`default_nettype wire
